>>> design/ekc_pkg.sv
// ----------------------------------------------------------------------------
// ekc_pkg
// Shared types, constants and helper functions for the EAPOL-Key classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package ekc_pkg;

    // Default saturation point of the per-frame byte counter
    localparam int MAX_FRAME_BYTES_DEF = 4095;

    // MAC header construction
    localparam logic [5:0]  MAC_HDR_BASE   = 6'd24;
    localparam logic [5:0]  MAC_HDR_ADDR4  = 6'd6;
    localparam logic [5:0]  MAC_HDR_QOS    = 6'd2;
    localparam logic [5:0]  MAC_HDR_HTC    = 6'd4;
    localparam logic [1:0]  FC_TYPE_DATA   = 2'b10;
    localparam logic [15:0] FC_DS_BOTH     = 16'h0300;
    localparam logic [15:0] FC_ORDER       = 16'h8000;

    // LLC/SNAP header carrying EtherType 888E
    localparam int SNAP_LEN = 8;
    localparam logic [7:0] SNAP_PATTERN [SNAP_LEN] =
        '{8'hAA, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h00, 8'h88, 8'h8E};

    // Offsets from the end of the SNAP header
    localparam int EAPOL_PACKET_TYPE_OFFSET = 1;
    localparam int KEY_DESC_OFFSET          = 4;
    localparam int FLAGS_HI_OFFSET          = 5;
    localparam int FLAGS_LO_OFFSET          = 6;

    localparam logic [7:0] EAPOL_TYPE_KEY = 8'h03;
    localparam logic [7:0] KEY_DESC_RSN   = 8'h02;

    // Length limits
    localparam int MIN_FRAME_LEN = 32;
    localparam int MIN_TAIL_LEN  = 18;
    localparam int FLAGS_END     = SNAP_LEN + FLAGS_LO_OFFSET + 1;

    // Message codes
    localparam logic [2:0] MSG_NONE = 3'd0;
    localparam logic [2:0] MSG_1    = 3'd1;
    localparam logic [2:0] MSG_2    = 3'd2;
    localparam logic [2:0] MSG_3    = 3'd3;
    localparam logic [2:0] MSG_4    = 3'd4;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       end_of_frame;
    } frame_item_t;

    typedef struct packed {
        logic [2:0]  message_number;
        logic [15:0] key_information;
    } class_item_t;

    function automatic logic [5:0] mac_header_bytes(input logic [15:0] fcw);
        logic [5:0] n;
        n = MAC_HDR_BASE;
        if (fcw[3:2] == FC_TYPE_DATA)
        begin
            if ((fcw & FC_DS_BOTH) == FC_DS_BOTH)
            begin
                n = n + MAC_HDR_ADDR4;
            end
            if (fcw[7])
            begin
                n = n + MAC_HDR_QOS;
            end
        end
        if ((fcw & FC_ORDER) != 16'h0000)
        begin
            n = n + MAC_HDR_HTC;
        end
        return n;
    endfunction

    // MIC, ACK, Install, Secure -> handshake message
    function automatic logic [2:0] classify(input logic [15:0] ki);
        logic [2:0] msg;
        case ({ki[8], ki[7], ki[6], ki[9]})
            4'b0100: msg = MSG_1;
            4'b1000: msg = MSG_2;
            4'b1111: msg = MSG_3;
            4'b1001: msg = MSG_4;
            default: msg = MSG_NONE;
        endcase
        return msg;
    endfunction

endpackage

`default_nettype wire

>>> design/ekc_in_stage.sv
// ----------------------------------------------------------------------------
// ekc_in_stage
// Input register: holds one accepted byte until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ekc_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 frame_valid,
    output logic                      frame_stall,
    input  wire ekc_pkg::frame_item_t frame_item,
    input  wire logic                 take,
    output logic                      held_valid,
    output ekc_pkg::frame_item_t      held_item
);
    import ekc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    frame_item_t item_reg;
    logic        accept;

    assign frame_stall = valid_reg && !take;
    assign accept      = frame_valid && !frame_stall;
    assign held_valid  = valid_reg;
    assign held_item   = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= frame_item;
        end
    end

endmodule

`default_nettype wire

>>> design/ekc_parser.sv
// ----------------------------------------------------------------------------
// ekc_parser
// Per-frame state and single-pass classification of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module ekc_parser #(
    parameter int MAX_FRAME_BYTES = ekc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 take,
    input  wire ekc_pkg::frame_item_t item,
    output ekc_pkg::class_item_t      result
);
    import ekc_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg,  pos_next;
    logic [15:0]      fcw_reg,  fcw_next;
    logic [5:0]       hl_reg,   hl_next;
    logic             enc_reg,  enc_next;
    logic [15:0]      ki_reg,   ki_next;

    logic [POS_W-1:0] hl_ext;
    logic [POS_W-1:0] rel;
    logic [POS_W-1:0] ext_ofs;
    logic [POS_W-1:0] hl_end;
    logic             ki_reached;
    logic             long_enough;
    logic [7:0]       b;

    assign b = item.frame_byte;

    always_comb
    begin
        fcw_next = fcw_reg;
        hl_next  = hl_reg;
        enc_next = enc_reg;
        ki_next  = ki_reg;
        hl_ext   = POS_W'(hl_reg);
        rel      = pos_reg - hl_ext;
        ext_ofs  = rel - POS_W'(SNAP_LEN);

        if (pos_reg == '0)
        begin
            fcw_next[7:0] = b;
        end
        else if (pos_reg == POS_W'(1))
        begin
            fcw_next[15:8] = b;
            hl_next        = mac_header_bytes({b, fcw_reg[7:0]});
        end
        else if (pos_reg >= hl_ext)
        begin
            if (rel < POS_W'(SNAP_LEN))
            begin
                if (b != SNAP_PATTERN[rel[2:0]])
                begin
                    enc_next = 1'b0;
                end
            end
            else
            begin
                if (ext_ofs == POS_W'(EAPOL_PACKET_TYPE_OFFSET) && b != EAPOL_TYPE_KEY)
                begin
                    enc_next = 1'b0;
                end
                if (ext_ofs == POS_W'(KEY_DESC_OFFSET) && b != KEY_DESC_RSN)
                begin
                    enc_next = 1'b0;
                end
                if (ext_ofs == POS_W'(FLAGS_HI_OFFSET))
                begin
                    ki_next[15:8] = b;
                end
                if (ext_ofs == POS_W'(FLAGS_LO_OFFSET))
                begin
                    ki_next[7:0] = b;
                end
            end
        end

        // saturating byte count
        pos_next = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + POS_W'(1);

        hl_end      = POS_W'(hl_next);
        ki_reached  = pos_next >= hl_end + POS_W'(FLAGS_END);
        long_enough = (pos_next >= POS_W'(MIN_FRAME_LEN))
                      && (pos_next >= hl_end + POS_W'(MIN_TAIL_LEN));

        result.key_information = ki_reached ? ki_next : 16'h0000;
        result.message_number  = (long_enough && enc_next) ? classify(ki_next) : MSG_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            fcw_reg <= 16'h0000;
            hl_reg  <= MAC_HDR_BASE;
            enc_reg <= 1'b1;
            ki_reg  <= 16'h0000;
        end
        else if (take)
        begin
            if (item.end_of_frame)
            begin
                pos_reg <= '0;
                fcw_reg <= 16'h0000;
                hl_reg  <= MAC_HDR_BASE;
                enc_reg <= 1'b1;
                ki_reg  <= 16'h0000;
            end
            else
            begin
                pos_reg <= pos_next;
                fcw_reg <= fcw_next;
                hl_reg  <= hl_next;
                enc_reg <= enc_next;
                ki_reg  <= ki_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_frame |=> pos_reg == '0 && enc_reg && hl_reg == MAC_HDR_BASE)
        else $error("frame state not cleared after last byte");

    a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("byte counter beyond saturation point");

    a_header_range: assert property (@(posedge clk) disable iff (!rst_n)
        hl_reg >= MAC_HDR_BASE && hl_reg <= MAC_HDR_BASE + MAC_HDR_ADDR4 + MAC_HDR_QOS
        + MAC_HDR_HTC)
        else $error("MAC header length out of range");

    a_msg_has_key_info: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.end_of_frame && result.message_number != MSG_NONE
        |-> result.key_information != 16'h0000 && result.message_number <= MSG_4)
        else $error("message reported without key information");
`endif

endmodule

`default_nettype wire

>>> design/ekc_out_stage.sv
// ----------------------------------------------------------------------------
// ekc_out_stage
// Result register: holds one classification until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module ekc_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 load,
    input  wire ekc_pkg::class_item_t result,
    output logic                      room,
    output logic                      class_valid,
    input  wire logic                 class_stall,
    output ekc_pkg::class_item_t      class_item
);
    import ekc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    class_item_t item_reg;

    // free now, or emptied at this edge
    assign room        = !valid_reg || !class_stall;
    assign class_valid = valid_reg;
    assign class_item  = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!class_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> design/eapol_key_message_classifier_top.sv
// ----------------------------------------------------------------------------
// eapol_key_message_classifier_top
// Classifies a byte-serial 802.11 frame as WPA handshake message 1 to 4.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock; only a last byte waits, on a full, stalled result register.
// A last byte's result enters the result register once it has room, then drives class_valid.
// The per-byte work is one pass of compare/add logic between the two registers.
// Reset (rst_n, async, active low) empties both registers and returns frame state
// to the start-of-frame values; no clearing pass is needed.
`default_nettype none

module eapol_key_message_classifier_top #(
    parameter int MAX_FRAME_BYTES = ekc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // byte stream in
    input  wire logic                 frame_valid,
    output logic                      frame_stall,
    input  wire ekc_pkg::frame_item_t frame_item,
    // classification out, one item per frame
    output logic                      class_valid,
    input  wire logic                 class_stall,
    output ekc_pkg::class_item_t      class_item
);
    import ekc_pkg::*;

    logic        held_valid;
    frame_item_t held_item;
    class_item_t result;
    logic        room;
    logic        take;
    logic        load;

    // A byte leaves the input register every cycle, except a last byte whose
    // result has nowhere to go yet.
    assign take = held_valid && (!held_item.end_of_frame || room);
    // Only the last byte of a frame produces an item.
    assign load = take && held_item.end_of_frame;

    ekc_in_stage u_in (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_item  (frame_item),
        .take        (take),
        .held_valid  (held_valid),
        .held_item   (held_item)
    );

    // Frame control, header length, SNAP/EAPOL checks and key-info capture
    ekc_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (held_item),
        .result (result)
    );

    ekc_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .result      (result),
        .room        (room),
        .class_valid (class_valid),
        .class_stall (class_stall),
        .class_item  (class_item)
    );

endmodule

`default_nettype wire

>>> dv/eapol_key_message_classifier_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eapol_key_message_classifier_top_test
// Self-checking bench for the EAPOL-Key classifier. Byte items are queued as
// whole frames (handshake messages, corrupted encapsulation, truncated, noise,
// one frame padded toward counter saturation), driven with random gaps, and every class item
// is compared with a cycle-free copy of the classification rules.
// ----------------------------------------------------------------------------

module eapol_key_message_classifier_top_test;

    import ekc_pkg::*;

    // Low saturation point so long frames hit it within the item budget; every
    // position that matters to the classification lies below it.
    localparam int          FRAME_LIMIT = 64;
    // LLC/SNAP header for EtherType 888E, first byte in the top octet
    localparam logic [63:0] SNAP_HDR    = 64'hAAAA_0300_0000_888E;

    typedef enum int {FR_GOOD, FR_FAULT, FR_CUT, FR_NOISE} frame_kind_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_stall;
    frame_item_t frame_item = '0;
    logic        class_valid;
    logic        class_stall = 1'b0;
    class_item_t class_item;

    eapol_key_message_classifier_top #(
        .MAX_FRAME_BYTES (FRAME_LIMIT)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_item  (frame_item),
        .class_valid (class_valid),
        .class_stall (class_stall),
        .class_item  (class_item)
    );

    always #4 clk = ~clk;

    // Stimulus and scoreboard storage
    frame_item_t byte_queue[$];        // byte items waiting for the driver
    class_item_t expected_class_q[$];  // classifications still to arrive
    logic [7:0]  frame_buf[$];         // frame under construction

    int  mismatches  = 0;
    bit  no_idle     = 1'b0;           // final stretch runs flat out
    bit  byte_taken  = 1'b0;           // byte item accepted at the last rising edge
    int  src_gap     = 0;
    int  sink_gap    = 0;

    // Frame-tracking state of the predictor
    logic [11:0] fr_pos   = '0;
    logic [15:0] fr_fcw   = '0;
    logic [5:0]  fr_hlen  = 6'd24;
    logic        fr_encap = 1'b1;
    logic [15:0] fr_ki    = '0;

    // MAC header length from the frame control word
    function automatic logic [5:0] hdr_len_of(input logic [15:0] fcw);
        int n;
        n = 24;
        if (fcw[3:2] == FC_TYPE_DATA)
        begin
            if (fcw[9:8] == 2'b11)
            begin
                n = n + 6;         // four-address frame
            end
            if (fcw[7])
            begin
                n = n + 2;         // QoS data subtype
            end
        end
        if (fcw[15])
        begin
            n = n + 4;             // order bit: HT control present
        end
        return n[5:0];
    endfunction

    // MIC / ACK / Install / Secure flags to message number
    function automatic logic [2:0] msg_of(input logic [15:0] ki);
        logic mic;
        logic ack;
        logic ins;
        logic sec;
        mic = ki[8];
        ack = ki[7];
        ins = ki[6];
        sec = ki[9];
        if (!mic && ack && !ins && !sec)
        begin
            return MSG_1;
        end
        if (mic && !ack && !ins && !sec)
        begin
            return MSG_2;
        end
        if (mic && ack && ins && sec)
        begin
            return MSG_3;
        end
        if (mic && !ack && !ins && sec)
        begin
            return MSG_4;
        end
        return MSG_NONE;
    endfunction

    // Advance the frame state by one accepted byte; at the last byte queue
    // the classification it must produce and return to start-of-frame state.
    task automatic classify_byte(input frame_item_t it);
        int          pos;
        int          hl;
        int          e;
        int          count;
        class_item_t res;
        pos = fr_pos;
        hl  = fr_hlen;
        if (pos == 0)
        begin
            fr_fcw[7:0] = it.frame_byte;
        end
        else if (pos == 1)
        begin
            fr_fcw[15:8] = it.frame_byte;
            fr_hlen      = hdr_len_of(fr_fcw);
        end
        else if (pos >= hl && pos < hl + SNAP_LEN)
        begin
            if (it.frame_byte != SNAP_HDR[63 - 8 * (pos - hl) -: 8])
            begin
                fr_encap = 1'b0;
            end
        end
        else if (pos >= hl + SNAP_LEN)
        begin
            e = pos - hl - SNAP_LEN;
            if (e == EAPOL_PACKET_TYPE_OFFSET && it.frame_byte != EAPOL_TYPE_KEY)
            begin
                fr_encap = 1'b0;
            end
            if (e == KEY_DESC_OFFSET && it.frame_byte != KEY_DESC_RSN)
            begin
                fr_encap = 1'b0;
            end
            if (e == FLAGS_HI_OFFSET)
            begin
                fr_ki[15:8] = it.frame_byte;
            end
            if (e == FLAGS_LO_OFFSET)
            begin
                fr_ki[7:0] = it.frame_byte;
            end
        end

        count = pos + 1;
        if (count > FRAME_LIMIT)
        begin
            count = FRAME_LIMIT;   // counter saturates, still counts as long
        end
        fr_pos = 12'(count);

        if (it.end_of_frame)
        begin
            hl                  = fr_hlen;
            res.message_number  = MSG_NONE;
            res.key_information = '0;
            if (count >= hl + SNAP_LEN + FLAGS_LO_OFFSET + 1)
            begin
                res.key_information = fr_ki;
            end
            if (count >= MIN_FRAME_LEN && count >= hl + MIN_TAIL_LEN && fr_encap)
            begin
                res.message_number = msg_of(fr_ki);
            end
            expected_class_q = {expected_class_q, res};
            fr_pos   = '0;
            fr_fcw   = '0;
            fr_hlen  = 6'd24;
            fr_encap = 1'b1;
            fr_ki    = '0;
        end
    endtask

    // Move the frame under construction into the byte queue
    task automatic queue_frame(output int n);
        frame_item_t it;
        n = frame_buf.size();
        for (int i = 0; i < n; i++)
        begin
            it.frame_byte   = frame_buf[i];
            it.end_of_frame = (i == n - 1);
            byte_queue = {byte_queue, it};
        end
        frame_buf.delete();
    endtask

    // EAPOL-Key frame: random MAC header, SNAP, EAPOL fields, key info, tail.
    // A fault corrupts one byte of the encapsulation; a cut truncates anywhere.
    task automatic build_eapol(input logic [2:0] msg_sel, input bit fault, input bit cut);
        logic [15:0] fc;
        logic [15:0] ki;
        int          hl;
        int          tail;
        int          idx;
        int          len;
        fc = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            fc[3:2] = FC_TYPE_DATA;
        end
        hl = hdr_len_of(fc);
        ki = 16'($urandom);
        case (msg_sel)
            MSG_1:   {ki[8], ki[7], ki[6], ki[9]} = 4'b0100;
            MSG_2:   {ki[8], ki[7], ki[6], ki[9]} = 4'b1000;
            MSG_3:   {ki[8], ki[7], ki[6], ki[9]} = 4'b1111;
            MSG_4:   {ki[8], ki[7], ki[6], ki[9]} = 4'b1001;
            default: ki = ki;   // arbitrary flag mix
        endcase
        frame_buf.delete();
        frame_buf = {frame_buf, fc[7:0]};
        frame_buf = {frame_buf, fc[15:8]};
        for (int i = 2; i < hl; i++)
        begin
            frame_buf = {frame_buf, 8'($urandom)};
        end
        for (int i = 0; i < SNAP_LEN; i++)
        begin
            frame_buf = {frame_buf, SNAP_HDR[63 - 8 * i -: 8]};
        end
        frame_buf = {frame_buf, 8'($urandom)};        // protocol version
        frame_buf = {frame_buf, EAPOL_TYPE_KEY};
        frame_buf = {frame_buf, 8'($urandom)};        // body length
        frame_buf = {frame_buf, 8'($urandom)};
        frame_buf = {frame_buf, KEY_DESC_RSN};
        frame_buf = {frame_buf, ki[15:8]};
        frame_buf = {frame_buf, ki[7:0]};
        // a tail of 0..2 leaves the frame just short of the minimum
        tail = $urandom_range(0, 40);
        for (int i = 0; i < tail; i++)
        begin
            frame_buf = {frame_buf, 8'($urandom)};
        end
        if (fault)
        begin
            idx = hl + $urandom_range(0, SNAP_LEN + FLAGS_HI_OFFSET - 1);
            frame_buf[idx] = frame_buf[idx] ^ 8'($urandom_range(1, 255));
        end
        if (cut)
        begin
            len = $urandom_range(1, frame_buf.size());
            while (frame_buf.size() > len)
            begin
                void'(frame_buf.pop_back());
            end
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || frame_valid || expected_class_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: new byte item only once the current one has gone or none is up.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
        end
        else if (!frame_valid || byte_taken)
        begin
            if (src_gap > 0)
            begin
                frame_valid <= 1'b0;
                src_gap     <= src_gap - 1;
            end
            else if (!no_idle && $urandom_range(0, 9) == 0)
            begin
                // idle burst; src_gap holds the idle cycles still to come
                frame_valid <= 1'b0;
                src_gap     <= $urandom_range(0, 4);
            end
            else if (byte_queue.size() != 0)
            begin
                frame_item  <= byte_queue.pop_front();
                frame_valid <= 1'b1;
            end
            else
            begin
                frame_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure in bursts; sink_gap holds the stall cycles still to come
    always @(negedge clk)
    begin
        if (!rst_n || no_idle)
        begin
            class_stall <= 1'b0;
            sink_gap    <= 0;
        end
        else if (sink_gap > 0)
        begin
            class_stall <= 1'b1;
            sink_gap    <= sink_gap - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            class_stall <= 1'b1;
            sink_gap    <= $urandom_range(0, 4);
        end
        else
        begin
            class_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on accepted bytes, checks accepted class items.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
        end
        else
        begin
            byte_taken <= frame_valid && !frame_stall;
            if (frame_valid && !frame_stall)
            begin
                classify_byte(frame_item);
            end
            if (class_valid && !class_stall)
            begin
                if (expected_class_q.size() == 0)
                begin
                    $display("%0t: unexpected class item msg %0d key_information %h",
                             $realtime, class_item.message_number,
                             class_item.key_information);
                    mismatches++;
                end
                else
                begin
                    if (class_item.message_number != expected_class_q[0].message_number)
                    begin
                        $display("%0t: message_number expected %0d actual %0d",
                                 $realtime, expected_class_q[0].message_number,
                                 class_item.message_number);
                        mismatches++;
                    end
                    if (class_item.key_information != expected_class_q[0].key_information)
                    begin
                        $display("%0t: key_information expected %h actual %h",
                                 $realtime, expected_class_q[0].key_information,
                                 class_item.key_information);
                        mismatches++;
                    end
                    void'(expected_class_q.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int          n;
        int          frames;
        int          rand_bytes;
        int          pad;
        frame_kind_t kind;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: one-byte frame, two-byte frame (ends as the header length
        // is worked out), then a short frame with every header option set.
        frame_buf = {frame_buf, 8'hFF};
        queue_frame(n);
        frame_buf = {frame_buf, 8'h00};
        frame_buf = {frame_buf, 8'hFF};
        queue_frame(n);
        frame_buf = {frame_buf, 8'h88};
        frame_buf = {frame_buf, 8'h83};
        for (int i = 2; i < 20; i++)
        begin
            frame_buf = {frame_buf, ((i % 2) ? 8'hFF : 8'h00)};
        end
        queue_frame(n);

        // sender holds off until every class item so far has come back
        wait_drained();

        // Random frames. The first four are the four handshake messages and
        // the fifth is padded to at least one byte short of the counter's saturation point.
        frames     = 0;
        rand_bytes = 0;
        while (rand_bytes < 1050 || frames < 8)
        begin
            if (frames < 4)
            begin
                build_eapol(3'(frames + 1), 1'b0, 1'b0);
                queue_frame(n);
                rand_bytes += n;
            end
            else if (frames == 4)
            begin
                build_eapol(MSG_3, 1'b0, 1'b0);
                pad = FRAME_LIMIT - 1 + int'($urandom_range(0, 7));
                while (frame_buf.size() < pad)
                begin
                    frame_buf = {frame_buf, 8'($urandom)};
                end
                queue_frame(n);
                rand_bytes += n;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    6:       kind = FR_FAULT;
                    7:       kind = FR_CUT;
                    8:       kind = FR_NOISE;
                    default: kind = FR_GOOD;
                endcase
                if (kind == FR_NOISE)
                begin
                    n = $urandom_range(1, 48);
                    for (int i = 0; i < n; i++)
                    begin
                        frame_buf = {frame_buf, 8'($urandom)};
                    end
                end
                else
                begin
                    build_eapol(3'($urandom_range(0, 4)), kind == FR_FAULT, kind == FR_CUT);
                end
                queue_frame(n);
                rand_bytes += n;
            end
            frames++;
        end
        wait_drained();

        // Closing stretch with no gaps and no back-pressure
        no_idle = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            build_eapol(3'($urandom_range(0, 4)), 1'b0, 1'b0);
            queue_frame(n);
        end
        wait_drained();
        repeat (4) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("PASS eapol_key_message_classifier_top");
        end
        else
        begin
            $display("FAIL eapol_key_message_classifier_top");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("FAIL eapol_key_message_classifier_top");
        $finish;
    end

endmodule
